@@ hdl/rht_pkg.sv @@
// Shared types and constants for the reference-counted handle table.
// Used by every module of the block; depends on nothing else.
package rht_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int HANDLE_W      = 6;
  localparam int CNT_W         = 7;
  localparam int RESET_SLOTS   = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_DUP     = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_FREE    = 2'd1;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] slot;
    logic [HANDLE_W-1:0] entry;
    logic                entry_freed;
  } rsp_t;

endpackage

@@ hdl/rht_slot_map.sv @@
// Slot occupancy bitmap, slot-to-entry mapping memory and lowest-free encoder.
// Depends on rht_pkg.
module rht_slot_map import rht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [IDX_W-1:0] rd_entry,
  output logic             used_rd,
  output logic             free_any,
  output logic [IDX_W-1:0] free_idx,
  input  logic             take_en,
  input  logic [IDX_W-1:0] take_idx,
  input  logic [IDX_W-1:0] take_entry,
  input  logic             drop_en,
  input  logic [IDX_W-1:0] drop_idx
);

  logic [SLOTS-1:0] used;
  logic [IDX_W-1:0] map_mem [SLOTS];
  logic [IDX_W-1:0] map_q;
  logic [IDX_W-1:0] rd_idx_q;
  // Slots 0 to 2 map to their own entry until first written.
  logic [RESET_SLOTS-1:0] mapped;
  logic             mapped_rd;
  logic [SLOTS-1:0] free_vec;
  logic [SLOTS-1:0] free_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= SLOTS'(3'b111);
      mapped <= '0;
    end else begin
      if (take_en) begin
        used[take_idx] <= 1'b1;
        if (take_idx < IDX_W'(RESET_SLOTS)) begin
          mapped[take_idx[1:0]] <= 1'b1;
        end
      end
      if (drop_en) begin
        used[drop_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_en) begin
      map_mem[take_idx] <= take_entry;
    end
    map_q    <= map_mem[rd_idx];
    rd_idx_q <= rd_idx;
  end

  always_comb begin
    mapped_rd = 1'b1;
    if (rd_idx_q == IDX_W'(0)) begin
      mapped_rd = mapped[0];
    end else if (rd_idx_q == IDX_W'(1)) begin
      mapped_rd = mapped[1];
    end else if (rd_idx_q == IDX_W'(2)) begin
      mapped_rd = mapped[2];
    end
  end

  assign rd_entry = mapped_rd ? map_q : rd_idx_q;
  assign used_rd  = used[rd_idx];

  // Isolate the lowest free bit, then encode the one-hot vector.
  assign free_vec = ~used;
  assign free_low = free_vec & (~free_vec + SLOTS'(1));
  assign free_any = |free_vec;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_low[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

endmodule

@@ hdl/rht_count_mem.sv @@
// Reference count memory with a post-reset initialization sweep.
// Depends on rht_pkg.
module rht_count_mem import rht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst,
  output logic             busy,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [CNT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [CNT_W-1:0] wr_data
);

  logic [CNT_W-1:0] cnt_mem [SLOTS];
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IDX_W'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Entries 0 to 2 start with one reference each; the rest start at zero.
  always_ff @(posedge clk) begin
    if (clearing) begin
      cnt_mem[clr_idx] <= (clr_idx < IDX_W'(RESET_SLOTS)) ? CNT_W'(1) : '0;
    end else if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    rd_data <= cnt_mem[rd_addr];
  end

  assign busy = clearing;

endmodule

@@ hdl/refcounted_handle_table_unit.sv @@
// Reference-counted handle table, top level. Depends on rht_pkg, rht_slot_map, rht_count_mem.
// Requests are handled one at a time, in the order map read, count read, count write-back;
// the result register is loaded in the write-back step, and a new request is taken after it.
// A result still waiting in the output register holds the block in its write-back cycle.
// Reset: synchronous; the count memory is initialized in a sweep after reset, and requests
// stay stalled until the sweep is done. Slots 0 to 2 start in use with a count of one.
module refcounted_handle_table_unit import rht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_CNT
  } state_t;

  state_t state;

  // Request captured at the transfer.
  logic [1:0]          r_req;
  logic [HANDLE_W-1:0] r_handle;
  logic [IDX_W-1:0]    r_hidx;
  logic                h_ok;
  logic                f_any;
  logic [IDX_W-1:0]    f_idx;
  logic [IDX_W-1:0]    e_idx;

  logic [IDX_W-1:0] hidx;
  logic             in_range;
  logic             req_take;
  logic             rsp_room;
  logic             finish;

  logic [IDX_W-1:0] map_entry;
  logic             used_rd;
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] e_sel;
  logic [IDX_W-1:0] cnt_addr;

  logic             cnt_busy;
  logic [CNT_W-1:0] cnt_rd;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  logic is_take;
  logic is_drop;
  rsp_t rsp_next;

  // The handle reaches only the first 64 slots; in a smaller table the
  // top handles are out of range.
  assign hidx     = IDX_W'(req.handle);
  assign in_range = 32'(req.handle) < 32'(SLOTS);
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;

  // A finished result may be loaded when the output register is empty or
  // its current transfer completes in this cycle.
  assign rsp_room = !rsp_valid || !rsp_stall;
  assign finish   = (state == S_CNT) && rsp_room;

  // An allocation maps to the entry of its own slot; the others follow the
  // mapping of the given handle read from memory.
  assign e_sel = (r_req == REQ_ALLOC) ? f_idx : map_entry;

  // While the result waits for the output register, the count keeps being read
  // from the captured entry, since the map read port has moved on by then.
  assign cnt_addr = (state == S_CNT) ? e_idx : e_sel;

  rht_slot_map #(
    .SLOTS(SLOTS)
  ) u_slot_map (
    .clk        (clk),
    .rst        (rst),
    .rd_idx     (hidx),
    .rd_entry   (map_entry),
    .used_rd    (used_rd),
    .free_any   (free_any),
    .free_idx   (free_idx),
    .take_en    (finish && is_take),
    .take_idx   (f_idx),
    .take_entry (e_idx),
    .drop_en    (finish && is_drop),
    .drop_idx   (r_hidx)
  );

  rht_count_mem #(
    .SLOTS(SLOTS)
  ) u_count_mem (
    .clk     (clk),
    .rst     (rst),
    .busy    (cnt_busy),
    .rd_addr (cnt_addr),
    .rd_data (cnt_rd),
    .wr_en   (finish && (is_take || is_drop)),
    .wr_addr (e_idx),
    .wr_data (is_take ? cnt_inc : cnt_dec)
  );

  // Counts saturate at the top and stop at zero.
  assign cnt_inc = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
  assign cnt_dec = (cnt_rd == '0) ? cnt_rd : cnt_rd - 1'b1;

  assign is_take = ((r_req == REQ_ALLOC) && f_any) ||
                   ((r_req == REQ_DUP) && h_ok && f_any);
  assign is_drop = (r_req == REQ_RELEASE) && h_ok;

  // A duplicate of a bad handle reports the bad handle before any lack of
  // free slots; an unknown request is treated as a bad handle.
  always_comb begin
    rsp_next = '0;
    priority if (is_take) begin
      rsp_next.status = ST_OK;
      rsp_next.slot   = HANDLE_W'(f_idx);
      rsp_next.entry  = HANDLE_W'(e_idx);
    end else if (is_drop) begin
      rsp_next.status      = ST_OK;
      rsp_next.slot        = r_handle;
      rsp_next.entry       = HANDLE_W'(e_idx);
      rsp_next.entry_freed = (cnt_dec == '0);
    end else if ((r_req == REQ_ALLOC) || ((r_req == REQ_DUP) && h_ok)) begin
      rsp_next.status = ST_NO_FREE;
    end else begin
      rsp_next.status = ST_BAD_HANDLE;
      rsp_next.slot   = r_handle;
    end
  end

  // Sequencer: the transfer cycle reads the map and samples the lowest free
  // slot, the next cycle reads the entry count, and the last cycle writes
  // both memories back and loads the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (!cnt_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          state <= S_CNT;
        end
        S_CNT: begin
          if (rsp_room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      r_req    <= req.req_type;
      r_handle <= req.handle;
      r_hidx   <= hidx;
      h_ok     <= in_range && used_rd;
      f_any    <= free_any;
      f_idx    <= free_idx;
    end
    if (state == S_MAP) begin
      e_idx <= e_sel;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ tb/handle_table_checker.sv @@
// Checker for the reference-counted handle table: watches both channels, keeps its own
// copy of the slot map and entry counts, and compares every response with its prediction.
// Depends on rht_pkg for the payload types, status and request codes.
module handle_table_checker import rht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int IDX_W = $clog2(SLOTS);

  logic             slot_busy   [SLOTS];
  logic [IDX_W-1:0] slot_target [SLOTS];
  logic [CNT_W-1:0] entry_refs  [SLOTS];

  rsp_t outcome_fifo[$];
  int   errs = 0;

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic rsp_t table_apply(req_t r);
    rsp_t             res;
    int               h;
    int               free_idx;
    int               i;
    logic             known;
    logic [IDX_W-1:0] tgt;
    res         = '0;
    res.status  = ST_OK;
    h           = r.handle;
    known       = (h < SLOTS) && slot_busy[h];
    free_idx    = -1;
    for (i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy[i]) free_idx = i;
    end
    case (r.req_type)
      REQ_ALLOC, REQ_DUP: begin
        if (r.req_type == REQ_DUP && !known) begin
          res.status = ST_BAD_HANDLE;
          res.slot   = r.handle;
        end else if (free_idx < 0) begin
          res.status = ST_NO_FREE;
        end else begin
          tgt = (r.req_type == REQ_ALLOC) ? IDX_W'(free_idx) : slot_target[h];
          slot_busy[free_idx]   = 1'b1;
          slot_target[free_idx] = tgt;
          if (entry_refs[tgt] != CNT_MAX) entry_refs[tgt] = entry_refs[tgt] + 1'b1;
          res.slot  = free_idx[HANDLE_W-1:0];
          res.entry = HANDLE_W'(tgt);
        end
      end
      REQ_RELEASE: begin
        if (!known) begin
          res.status = ST_BAD_HANDLE;
          res.slot   = r.handle;
        end else begin
          tgt = slot_target[h];
          if (entry_refs[tgt] != '0) entry_refs[tgt] = entry_refs[tgt] - 1'b1;
          slot_busy[h]    = 1'b0;
          res.slot        = r.handle;
          res.entry       = HANDLE_W'(tgt);
          res.entry_freed = (entry_refs[tgt] == '0);
        end
      end
      default: begin
        res.status = ST_BAD_HANDLE;
        res.slot   = r.handle;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i]   = (i < RESET_SLOTS);
        slot_target[i] = IDX_W'(i);
        entry_refs[i]  = (i < RESET_SLOTS) ? CNT_W'(1) : '0;
      end
      outcome_fifo.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (outcome_fifo.size() == 0) begin
          $error("response with nothing outstanding: status %0d slot %0d entry %0d",
                 rsp.status, rsp.slot, rsp.entry);
          errs++;
        end else begin
          want = outcome_fifo.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
            errs++;
          end
          if (rsp.entry !== want.entry) begin
            $error("entry: expected %0d, got %0d", want.entry, rsp.entry);
            errs++;
          end
          if (rsp.entry_freed !== want.entry_freed) begin
            $error("entry_freed: expected %0d, got %0d", want.entry_freed, rsp.entry_freed);
            errs++;
          end
        end
      end
      if (req_valid && !req_stall) outcome_fifo.push_back(table_apply(req));
    end
    mismatches  <= errs;
    outstanding <= outcome_fifo.size();
  end

endmodule

@@ tb/tb_refcounted_handle_table_unit.sv @@
// Top of the handle table testbench: clock, reset, request stimulus and response stalls.
// Depends on rht_pkg, refcounted_handle_table_unit and handle_table_checker.
module tb_refcounted_handle_table_unit;
  import rht_pkg::*;

  // Request code outside the defined set; the block must answer it as a bad handle.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int RANDOM_ITEMS = 1950;
  // The slowest correct run draws the longest idle gaps on both sides on every transfer,
  // and this limit leaves several times its length as margin.
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int { FILL, DRAIN, CHURN } bias_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int   mismatches;
  int   outstanding;
  int   cycles    = 0;
  bit   req_burst = 1'b0;

  refcounted_handle_table_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  handle_table_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog. A hung handshake on either side ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Presents one request and returns after the edge at which its transfer happened.
  // With no idle cycles drawn, valid simply stays high and the payload changes in place,
  // so the next request is offered as soon as the last one has transferred.
  task automatic send_req(input logic [1:0] kind, input logic [HANDLE_W-1:0] h);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{req_type: kind, handle: h};
    do @(posedge clk); while (req_stall);
  endtask

  // Response side. For each transfer it holds stall for a random number of cycles first,
  // and now and then runs a calm stretch where every response is taken at once. The
  // stall is raised whether or not a response is waiting, so it lands on every phase of
  // the block's pipeline.
  initial begin
    int hold;
    int calm;
    calm = 0;
    @(posedge clk);
    forever begin
      if (calm > 0) begin
        hold = 0;
        calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        calm = $urandom_range(20, 60);
        hold = 0;
      end else begin
        hold = $urandom_range(0, 13);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  initial begin
    bias_t             bias;
    int                sent;
    int                phase_len;
    int                roll;
    logic [1:0]        kind;
    logic [HANDLE_W-1:0] h;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. After reset slots 0 to 2 are in use, each on its own entry with a
    // count of one. The block may still be clearing its count memory; the first
    // transfer simply waits for stall to drop.
    send_req(REQ_ALLOC,   '0);   // lowest free slot is 3, on entry 3
    send_req(REQ_DUP,     6'd0); // slot 4 shares entry 0, count goes to two
    send_req(REQ_DUP,     6'd4); // duplicate of a duplicate: slot 5, still entry 0
    send_req(REQ_RELEASE, 6'd0); // entry 0 keeps two references
    send_req(REQ_RELEASE, 6'd4);
    send_req(REQ_RELEASE, 6'd5); // last reference gone, the entry is reported freed
    send_req(REQ_RELEASE, 6'd0); // slot 0 is free now, so this is a bad handle
    send_req(REQ_DUP,     6'd0); // duplicating a free slot is a bad handle too
    send_req(REQ_DUP,     6'd63);
    send_req(REQ_RELEASE, 6'd63);
    send_req(REQ_UNKNOWN, 6'd63); // undefined request code
    send_req(REQ_UNKNOWN, 6'd0);
    send_req(REQ_ALLOC,   6'd63); // handle is ignored; lowest free slot 0 is taken
    send_req(REQ_DUP,     6'd3);
    send_req(REQ_RELEASE, 6'd1);
    send_req(REQ_RELEASE, 6'd2);
    send_req(REQ_RELEASE, 6'd3);  // entry 3 still has the reference from the duplicate
    send_req(REQ_ALLOC,   6'd42);

    // Random part, in phases. Filling phases push the table toward full, so the no-free-slot
    // answer can show up; draining phases bring it back down. Handles lean toward low slots,
    // where the lowest-free rule keeps the live ones.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      bias      = bias_t'($urandom_range(0, 2));
      req_burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 160);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        case (bias)
          FILL:    kind = (roll < 70) ? REQ_ALLOC : (roll < 90) ? REQ_DUP :
                          (roll < 98) ? REQ_RELEASE : REQ_UNKNOWN;
          DRAIN:   kind = (roll < 8) ? REQ_ALLOC : (roll < 18) ? REQ_DUP :
                          (roll < 98) ? REQ_RELEASE : REQ_UNKNOWN;
          default: kind = (roll < 30) ? REQ_ALLOC : (roll < 60) ? REQ_DUP :
                          (roll < 98) ? REQ_RELEASE : REQ_UNKNOWN;
        endcase
        h = $urandom_range(0, 1) ? HANDLE_W'($urandom_range(0, 63))
                                 : HANDLE_W'($urandom_range(0, 11));
        send_req(kind, h);
        sent++;
      end
    end
    req_valid <= 1'b0;

    // Drain: wait for every predicted response, then keep clocking so that a stray extra
    // response would still be caught.
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
